/* design/linear_recurrence_scan_with_gradient_top_assert.svh */
// Assertion macros used by the scan block's back end.
`ifndef LINEAR_RECURRENCE_SCAN_WITH_GRADIENT_TOP_ASSERT_SVH
`define LINEAR_RECURRENCE_SCAN_WITH_GRADIENT_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LRSG_CHECK_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define LRSG_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lrsg_pkg.sv */
// Package with types, constants and fixed-point helpers of the scan block.
`default_nettype none
package lrsg_pkg;

  localparam int MAX_LEN_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int STEP_W        = 6;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic                     first_item;
    logic                     last_item;
    logic signed [DATA_W-1:0] coef_a;
    logic signed [DATA_W-1:0] value_in;
    logic signed [DATA_W-1:0] initial_state;
    logic signed [DATA_W-1:0] prev_state;
  } lrsg_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] state_out;
    logic signed [DATA_W-1:0] grad_coef;
    logic signed [DATA_W-1:0] grad_initial;
    logic        [STEP_W-1:0] step_index;
    logic                     last_result;
    logic                     overflow;
  } lrsg_res_t;

  // Classified request handed from the front to the back.
  // step: buffer slot on a write, forward position, or walk start.
  typedef struct packed {
    logic                     mode;
    logic                     first_item;
    logic                     last_item;
    logic                     wen;
    logic                     ovf;
    logic        [STEP_W-1:0] step;
    logic signed [DATA_W-1:0] coef_a;
    logic signed [DATA_W-1:0] value_in;
    logic signed [DATA_W-1:0] initial_state;
    logic signed [DATA_W-1:0] prev_state;
  } lrsg_cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } lrsg_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FWD,
    BK_RD,
    BK_SUM,
    BK_MUL,
    BK_EMIT
  } back_state_t;

  function automatic logic signed [DATA_W-1:0] fx_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      fx_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      fx_add = s[DATA_W-1:0];
    end
  endfunction

  // Drop the fraction bits of a full product (floor), then saturate.
  function automatic logic signed [DATA_W-1:0] fx_scale(input logic signed [2*DATA_W-1:0] p,
                                                        input int unsigned sh);
    logic signed [2*DATA_W-1:0] q;
    q = p >>> sh;
    if (q > 64'sh0000_0000_7fff_ffff) begin
      fx_scale = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (q < 64'shffff_ffff_8000_0000) begin
      fx_scale = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      fx_scale = q[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* design/lrsg_front.sv */
// Front end: accepts requests, tracks fill count and overflow, classifies them.
`default_nettype none
module lrsg_front #(
  parameter int MAX_LEN = lrsg_pkg::MAX_LEN_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  lrsg_pkg::lrsg_req_t req_data,
  input  lrsg_pkg::lrsg_qstat_t qstat,
  output logic                push,
  output lrsg_pkg::lrsg_cmd_t push_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             overflow_flag, overflow_flag_next;

  logic [CNT_W-1:0] fc, fc_new, step_wide;
  logic             of, full;

  always_comb begin
    fc        = req_data.first_item ? '0 : fill_count;
    of        = req_data.first_item ? 1'b0 : overflow_flag;
    full      = (fc >= CNT_W'(MAX_LEN));
    fc_new    = full ? fc : fc + CNT_W'(1);
    step_wide = fc_new - CNT_W'(1);

    req_stall = qstat.full;
    push      = req_valid && !qstat.full;

    push_data.mode          = req_data.mode;
    push_data.first_item    = req_data.first_item;
    push_data.last_item     = req_data.last_item;
    push_data.wen           = !full;
    push_data.ovf           = of || full;
    push_data.step          = lrsg_pkg::STEP_W'(step_wide);
    push_data.coef_a        = req_data.coef_a;
    push_data.value_in      = req_data.value_in;
    push_data.initial_state = req_data.initial_state;
    push_data.prev_state    = req_data.prev_state;

    fill_count_next    = fill_count;
    overflow_flag_next = overflow_flag;
    if (push) begin
      if (req_data.last_item) begin
        fill_count_next    = '0;
        overflow_flag_next = 1'b0;
      end else begin
        fill_count_next    = fc_new;
        overflow_flag_next = of || full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      fill_count    <= fill_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule
`default_nettype wire

/* design/lrsg_queue.sv */
// Short command queue between the front end and the back end.
`default_nettype none
module lrsg_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  lrsg_pkg::lrsg_cmd_t   push_data,
  input  wire                   pop,
  output lrsg_pkg::lrsg_qstat_t qstat,
  output lrsg_pkg::lrsg_cmd_t   head
);

  localparam int PTR_W = (lrsg_pkg::QUEUE_DEPTH > 1) ? $clog2(lrsg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lrsg_pkg::QUEUE_DEPTH + 1);

  lrsg_pkg::lrsg_cmd_t slots [lrsg_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(lrsg_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    qstat.full     = (count == CNT_W'(lrsg_pkg::QUEUE_DEPTH));
    qstat.nonempty = (count != '0);
    do_push        = push && !qstat.full;
    do_pop         = pop && qstat.nonempty;
    head           = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/lrsg_back.sv */
// Back end: forward multiply-add, history buffers and reverse gradient walk.
`default_nettype none
`include "linear_recurrence_scan_with_gradient_top_assert.svh"
module lrsg_back #(
  parameter int MAX_LEN   = lrsg_pkg::MAX_LEN_DEF,
  parameter int FRAC_BITS = lrsg_pkg::FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  lrsg_pkg::lrsg_qstat_t qstat,
  input  lrsg_pkg::lrsg_cmd_t   cmd,
  output logic                  cmd_pop,
  output logic                  res_valid,
  input  wire                   res_stall,
  output lrsg_pkg::lrsg_res_t   res_data
);

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW     = lrsg_pkg::DATA_W;

  lrsg_pkg::back_state_t state, state_next;

  logic signed [DW-1:0] coef_mem [MAX_LEN];
  logic signed [DW-1:0] grad_mem [MAX_LEN];
  logic signed [DW-1:0] prev_mem [MAX_LEN];

  logic signed [DW-1:0]   running_value;
  logic signed [2*DW-1:0] prod_h, prod_ga, prod_gn;
  logic signed [DW-1:0]   fwd_v;
  logic [lrsg_pkg::STEP_W-1:0] fwd_t;
  logic                   fwd_last, fwd_ovf;
  logic [ADDR_W-1:0]      walk_k;
  logic                   walk_ovf;
  logic signed [DW-1:0]   g_acc, g_sum;
  logic signed [DW-1:0]   rd_coef, rd_grad, rd_prev;

  logic signed [DW-1:0] hprev, bprev, cmd_a;
  logic signed [DW-1:0] wr_grad, wr_prev, fwd_h, walk_ga, walk_gn;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_en, rd_en, load_res, out_free;
  lrsg_pkg::lrsg_res_t  res_next;
  logic                 pop_fwd, walk_done, walk_busy;

  always_comb begin
    cmd_a    = cmd.coef_a;
    hprev    = cmd.first_item ? cmd.initial_state : running_value;
    bprev    = cmd.first_item ? cmd.initial_state : cmd.prev_state;
    wr_grad  = (cmd.mode == lrsg_pkg::MODE_BWD) ? cmd.value_in : '0;
    wr_prev  = (cmd.mode == lrsg_pkg::MODE_BWD) ? bprev : hprev;
    wr_addr  = cmd.step[ADDR_W-1:0];
    out_free = !res_valid || !res_stall;
    fwd_h    = lrsg_pkg::fx_add(lrsg_pkg::fx_scale(prod_h, FRAC_BITS), fwd_v);
    walk_ga  = lrsg_pkg::fx_scale(prod_ga, FRAC_BITS);
    walk_gn  = lrsg_pkg::fx_scale(prod_gn, FRAC_BITS);

    state_next = state;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    load_res   = 1'b0;
    res_next   = '0;

    unique case (state)
      lrsg_pkg::BK_IDLE: begin
        if (qstat.nonempty) begin
          cmd_pop = 1'b1;
          wr_en   = cmd.wen;
          if (cmd.mode == lrsg_pkg::MODE_FWD) begin
            state_next = lrsg_pkg::BK_FWD;
          end else if (cmd.last_item) begin
            state_next = lrsg_pkg::BK_RD;
          end
        end
      end
      lrsg_pkg::BK_FWD: begin
        res_next.state_out   = fwd_h;
        res_next.step_index  = fwd_t;
        res_next.last_result = fwd_last;
        res_next.overflow    = fwd_ovf;
        if (out_free) begin
          load_res   = 1'b1;
          state_next = lrsg_pkg::BK_IDLE;
        end
      end
      lrsg_pkg::BK_RD: begin
        rd_en      = 1'b1;
        state_next = lrsg_pkg::BK_SUM;
      end
      lrsg_pkg::BK_SUM: begin
        state_next = lrsg_pkg::BK_MUL;
      end
      lrsg_pkg::BK_MUL: begin
        state_next = lrsg_pkg::BK_EMIT;
      end
      lrsg_pkg::BK_EMIT: begin
        res_next.state_out    = g_sum;
        res_next.grad_coef    = walk_ga;
        res_next.grad_initial = (walk_k == '0) ? walk_gn : '0;
        res_next.step_index   = lrsg_pkg::STEP_W'(walk_k);
        res_next.last_result  = (walk_k == '0);
        res_next.overflow     = walk_ovf;
        if (out_free) begin
          load_res   = 1'b1;
          state_next = (walk_k == '0) ? lrsg_pkg::BK_IDLE : lrsg_pkg::BK_RD;
        end
      end
      default: begin
        state_next = lrsg_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_fwd   = cmd_pop && (cmd.mode == lrsg_pkg::MODE_FWD);
    walk_done = (state == lrsg_pkg::BK_EMIT) && load_res && (walk_k == '0);
    walk_busy = (state != lrsg_pkg::BK_IDLE) && (state != lrsg_pkg::BK_FWD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrsg_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // History buffers: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= cmd_a;
      grad_mem[wr_addr] <= wr_grad;
      prev_mem[wr_addr] <= wr_prev;
    end
    if (rd_en) begin
      rd_coef <= coef_mem[walk_k];
      rd_grad <= grad_mem[walk_k];
      rd_prev <= prev_mem[walk_k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_value <= '0;
    end else if (state == lrsg_pkg::BK_FWD && load_res) begin
      running_value <= fwd_h;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      prod_h   <= cmd_a * hprev;
      fwd_v    <= cmd.value_in;
      fwd_t    <= cmd.step;
      fwd_last <= cmd.last_item;
      fwd_ovf  <= cmd.ovf;
      walk_k   <= cmd.step[ADDR_W-1:0];
      walk_ovf <= cmd.ovf;
      g_acc    <= '0;
    end
    if (state == lrsg_pkg::BK_SUM) begin
      g_sum <= lrsg_pkg::fx_add(g_acc, rd_grad);
    end
    if (state == lrsg_pkg::BK_MUL) begin
      prod_ga <= rd_prev * g_sum;
      prod_gn <= rd_coef * g_sum;
    end
    if (state == lrsg_pkg::BK_EMIT && load_res) begin
      g_acc  <= walk_gn;
      walk_k <= walk_k - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_data <= res_next;
    end
  end

  `LRSG_CHECK_NEXT(a_fwd_pop_to_mul, pop_fwd, state == lrsg_pkg::BK_FWD, "forward request lost")
  `LRSG_CHECK_NEXT(a_walk_end_idle, walk_done, state == lrsg_pkg::BK_IDLE, "walk overran")
  `LRSG_CHECK_NOW(a_walk_in_range, !walk_busy || int'(walk_k) < MAX_LEN, "bad walk address")

endmodule
`default_nettype wire

/* design/linear_recurrence_scan_with_gradient_top.sv */
// Top level of the linear recurrence scan with gradient pass.
`default_nettype none
// One channel's sequence at a time. A forward request (mode 0) computes
// h = a*h_prev + b in Q(FRAC_BITS) with floor truncation and saturation and
// returns one result: the 32x32 product is registered when the back end
// takes the request, then scaling, the add and the output register follow.
// The running value feeds the next forward request, so the back end takes
// the next one only after the current result is loaded. A backward request
// (mode 1) only stores a, the incoming gradient and the previous output in
// the history buffers; on a backward last request the back end walks the
// buffer from the newest slot down to slot 0, slot by slot (buffer read,
// gradient add, two parallel multiplies, scale and output), and returns N
// results for N buffered items, the one at slot 0 carrying last_result and
// the initial-state gradient. A sequence longer than MAX_LEN keeps the
// first MAX_LEN items and flags overflow. A two-entry command queue sits
// between the request side and the back end, and an output register sits on
// the result side, so requests keep being taken while a result waits. The
// buffers need no clearing after reset.
module linear_recurrence_scan_with_gradient_top #(
  parameter int MAX_LEN   = lrsg_pkg::MAX_LEN_DEF,
  parameter int FRAC_BITS = lrsg_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  lrsg_pkg::lrsg_req_t req_data,
  output logic                res_valid,
  input  wire                 res_stall,
  output lrsg_pkg::lrsg_res_t res_data
);

  lrsg_pkg::lrsg_qstat_t qstat;
  lrsg_pkg::lrsg_cmd_t   push_data, head;
  logic                  push, pop;

  lrsg_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  lrsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .qstat     (qstat),
    .head      (head)
  );

  lrsg_back #(
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .cmd       (head),
    .cmd_pop   (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
`default_nettype wire
